FILE: hw/rtl/graph_bfs_dfs_traversal_defines.svh
// Assertion macros shared by the graph walker RTL.
// Used by graph_bfs_dfs_traversal.sv; expects signals clock and reset in scope.
`ifndef GRAPH_BFS_DFS_TRAVERSAL_DEFINES_SVH
`define GRAPH_BFS_DFS_TRAVERSAL_DEFINES_SVH

// same-cycle implication, checked outside reset
`define GBT_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("graph walker: same-cycle check failed");

// next-cycle implication, checked outside reset
`define GBT_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("graph walker: next-cycle check failed");

`endif

FILE: hw/rtl/gbt_pkg.sv
// Shared constants and types of the graph walker.
// No dependencies; used by gbt_emit and graph_bfs_dfs_traversal.
package gbt_pkg;

   localparam int MAX_VERTICES_DEF = 64;
   localparam int MAX_EDGES_DEF    = 256;
   localparam int VERTEX_W         = 6;
   localparam int LIMIT_W          = 7;

   localparam logic [1:0] CMD_ADD_EDGE = 2'd0;
   localparam logic [1:0] CMD_BFS      = 2'd1;
   localparam logic [1:0] CMD_DFS      = 2'd2;
   localparam logic [1:0] CMD_NOP      = 2'd3;

   localparam logic REG_NUM_VERTICES = 1'b0;
   localparam logic REG_START_VERTEX = 1'b1;

   typedef struct packed {
      logic start;
      logic complete;
      logic dropped;
   } emit_ctl_type;

endpackage

FILE: hw/rtl/graph_bfs_dfs_traversal.sv
// Graph walker. An add-edge item reads (S_APP_RD) and writes (S_APP_WR) one
// entry, twice with both_ways; a dropped add or an unused command leaves the
// walker idle. A walk runs S_W_INIT, then per visited vertex S_W_POP and
// S_W_VIS, S_W_FIRST for a non-empty list and S_W_EDGE per list entry, then
// S_W_DONE, and then gives one result per cycle; a start vertex out of range
// returns to idle from S_W_INIT. Memory reads are registered, one entry a
// cycle. busy stays high until the last result is out; results cannot be
// held off, so each rsp_valid pulse must be taken when it comes.
// Depends on gbt_pkg, gbt_emit and graph_bfs_dfs_traversal_defines.svh.
`include "graph_bfs_dfs_traversal_defines.svh"
module graph_bfs_dfs_traversal #(
   parameter int MAX_VERTICES = gbt_pkg::MAX_VERTICES_DEF,
   parameter int MAX_EDGES    = gbt_pkg::MAX_EDGES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_command,
   input  logic [gbt_pkg::VERTEX_W-1:0]  req_from_vertex,
   input  logic [gbt_pkg::VERTEX_W-1:0]  req_to_vertex,
   input  logic                          req_both_ways,
   output logic                          rsp_valid,
   output logic [gbt_pkg::VERTEX_W-1:0]  rsp_vertex,
   output logic                          rsp_last,
   output logic                          rsp_complete,
   output logic                          rsp_edges_dropped,
   input  logic                          csr_write,
   input  logic                          csr_index,
   input  logic [gbt_pkg::LIMIT_W-1:0]   csr_data
);
   import gbt_pkg::*;

   localparam int AW  = $clog2(MAX_VERTICES);
   localparam int CW  = $clog2(MAX_VERTICES + 1);
   localparam int EW  = $clog2(MAX_EDGES);
   localparam int ECW = $clog2(MAX_EDGES + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_APP_RD, S_APP_WR, S_W_INIT, S_W_POP, S_W_VIS, S_W_FIRST, S_W_EDGE,
      S_W_DONE
   } state_type;

   state_type state_ff;

   logic [LIMIT_W-1:0]  num_vertices_ff;
   logic [VERTEX_W-1:0] start_vertex_ff;
   logic [LIMIT_W-1:0]  lim;

   logic [VERTEX_W-1:0] edge_target [MAX_EDGES];
   logic [EW-1:0]       edge_link   [MAX_EDGES];
   logic [EW-1:0]       list_first  [MAX_VERTICES];
   logic [EW-1:0]       list_final  [MAX_VERTICES];
   logic [VERTEX_W-1:0] order_store [MAX_VERTICES];

   logic [VERTEX_W-1:0] target_rd_ff;
   logic [EW-1:0]       link_rd_ff, first_rd_ff, final_rd_ff;
   logic [VERTEX_W-1:0] order_rd_ff;

   logic [MAX_VERTICES-1:0] nonempty_ff, seen_ff;
   logic [ECW-1:0]      edge_count_ff;
   logic                dropped_ff;
   logic [CW-1:0]       front_ff, back_ff, count_ff, back_dec;
   logic                dfs_ff, pend_rev_ff;
   logic [VERTEX_W-1:0] src_ff, dst_ff;
   logic [EW-1:0]       idx_ff, idx_in, fin_ff;

   logic [EW-1:0]       edge_raddr;
   logic [AW-1:0]       list_raddr, order_raddr;
   logic                emit_busy, accept, w_ok;
   logic [VERTEX_W-1:0] w;
   emit_ctl_type        emit_ctl;

   assign lim = (num_vertices_ff == '0) ? LIMIT_W'(1)
              : (num_vertices_ff > LIMIT_W'(MAX_VERTICES)) ? LIMIT_W'(MAX_VERTICES)
              : num_vertices_ff;

   assign accept   = start & ~busy;
   assign back_dec = back_ff - CW'(1);
   assign w        = target_rd_ff;
   assign w_ok     = ({1'b0, w} < lim) && !seen_ff[w[AW-1:0]]
                   && (back_ff < CW'(MAX_VERTICES));
   assign idx_in   = link_rd_ff;

   // read addresses, issued the cycle before the registered data is used
   always_comb begin
      list_raddr  = (state_ff == S_APP_RD) ? src_ff[AW-1:0] : order_rd_ff[AW-1:0];
      order_raddr = dfs_ff ? back_dec[AW-1:0] : front_ff[AW-1:0];
      edge_raddr  = (state_ff == S_W_FIRST) ? first_rd_ff : idx_in;
   end

   always_ff @(posedge clock) begin
      target_rd_ff <= edge_target[edge_raddr];
      link_rd_ff   <= edge_link[edge_raddr];
      first_rd_ff  <= list_first[list_raddr];
      final_rd_ff  <= list_final[list_raddr];
      order_rd_ff  <= order_store[order_raddr];
      if (state_ff == S_APP_WR && edge_count_ff != ECW'(MAX_EDGES)) begin
         edge_target[edge_count_ff[EW-1:0]] <= dst_ff;
         list_final[src_ff[AW-1:0]]         <= edge_count_ff[EW-1:0];
         if (nonempty_ff[src_ff[AW-1:0]]) begin
            edge_link[final_rd_ff] <= edge_count_ff[EW-1:0];
         end else begin
            list_first[src_ff[AW-1:0]] <= edge_count_ff[EW-1:0];
         end
      end
      if (state_ff == S_W_INIT) begin
         order_store[0] <= start_vertex_ff;
      end else if (state_ff == S_W_EDGE && w_ok) begin
         order_store[back_ff[AW-1:0]] <= w;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         num_vertices_ff <= LIMIT_W'(64);
         start_vertex_ff <= '0;
         nonempty_ff     <= '0;
         seen_ff         <= '0;
         edge_count_ff   <= '0;
         dropped_ff      <= 1'b0;
         front_ff        <= '0;
         back_ff         <= '0;
         count_ff        <= '0;
         dfs_ff          <= 1'b0;
         pend_rev_ff     <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               REG_NUM_VERTICES: num_vertices_ff <= csr_data;
               REG_START_VERTEX: start_vertex_ff <= csr_data[VERTEX_W-1:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  src_ff      <= req_from_vertex;
                  dst_ff      <= req_to_vertex;
                  pend_rev_ff <= req_both_ways;
                  dfs_ff      <= (req_command == CMD_DFS);
                  unique case (req_command)
                     CMD_ADD_EDGE: begin
                        if ({1'b0, req_from_vertex} >= lim
                            || {1'b0, req_to_vertex} >= lim) begin
                           dropped_ff <= 1'b1;
                        end else begin
                           state_ff <= S_APP_RD;
                        end
                     end
                     CMD_BFS, CMD_DFS: state_ff <= S_W_INIT;
                     default: ;
                  endcase
               end
            end
            S_APP_RD: state_ff <= S_APP_WR;
            S_APP_WR: begin
               if (edge_count_ff == ECW'(MAX_EDGES)) begin
                  dropped_ff <= 1'b1;
               end else begin
                  edge_count_ff                <= edge_count_ff + ECW'(1);
                  nonempty_ff[src_ff[AW-1:0]]  <= 1'b1;
               end
               if (pend_rev_ff) begin
                  pend_rev_ff <= 1'b0;
                  src_ff      <= dst_ff;
                  dst_ff      <= src_ff;
                  state_ff    <= S_APP_RD;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_W_INIT: begin
               front_ff <= '0;
               count_ff <= '0;
               if ({1'b0, start_vertex_ff} >= lim) begin
                  seen_ff  <= '0;
                  back_ff  <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  back_ff  <= CW'(1);
                  seen_ff  <= {{(MAX_VERTICES-1){1'b0}}, 1'b1} << start_vertex_ff[AW-1:0];
                  state_ff <= S_W_POP;
               end
            end
            S_W_POP: begin
               if (LIMIT_W'(count_ff) < lim && back_ff > front_ff) begin
                  if (dfs_ff) begin
                     back_ff <= back_dec;
                  end else begin
                     front_ff <= front_ff + CW'(1);
                  end
                  state_ff <= S_W_VIS;
               end else begin
                  state_ff <= S_W_DONE;
               end
            end
            S_W_VIS: begin
               count_ff <= count_ff + CW'(1);
               state_ff <= nonempty_ff[order_rd_ff[AW-1:0]] ? S_W_FIRST : S_W_POP;
            end
            S_W_FIRST: begin
               idx_ff   <= first_rd_ff;
               fin_ff   <= final_rd_ff;
               state_ff <= S_W_EDGE;
            end
            S_W_EDGE: begin
               if (w_ok) begin
                  seen_ff[w[AW-1:0]] <= 1'b1;
                  back_ff            <= back_ff + CW'(1);
               end
               if (idx_ff == fin_ff) begin
                  state_ff <= S_W_POP;
               end else begin
                  idx_ff <= idx_in;
               end
            end
            S_W_DONE: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      emit_ctl.start    = (state_ff == S_W_DONE) && (count_ff != '0);
      emit_ctl.complete = (LIMIT_W'(count_ff) == lim);
      emit_ctl.dropped  = dropped_ff;
   end

   gbt_emit #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_emit (
      .clock             (clock),
      .reset             (reset),
      .visit_we          (state_ff == S_W_VIS),
      .visit_addr        (count_ff[AW-1:0]),
      .visit_data        (order_rd_ff),
      .ctl               (emit_ctl),
      .count             (count_ff),
      .busy              (emit_busy),
      .rsp_valid         (rsp_valid),
      .rsp_vertex        (rsp_vertex),
      .rsp_last          (rsp_last),
      .rsp_complete      (rsp_complete),
      .rsp_edges_dropped (rsp_edges_dropped)
   );

   assign busy = (state_ff != S_IDLE) || emit_busy;

   `GBT_ASSERT_IMP(a_rsp_while_busy, rsp_valid, busy)
   `GBT_ASSERT_IMP(a_stack_bound, 1'b1, back_ff <= CW'(MAX_VERTICES))
   `GBT_ASSERT_IMP(a_count_bound, state_ff == S_W_POP, LIMIT_W'(count_ff) <= lim)
   `GBT_ASSERT_NXT(a_walk_goes_busy, accept && req_command == CMD_BFS, busy)

endmodule

FILE: hw/rtl/gbt_emit.sv
// Result emitter: holds the visit order of a walk and plays it out, one item a cycle.
// Depends on gbt_pkg.
module gbt_emit #(
   parameter int MAX_VERTICES = gbt_pkg::MAX_VERTICES_DEF,
   parameter int AW = $clog2(MAX_VERTICES),
   parameter int CW = $clog2(MAX_VERTICES + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          visit_we,
   input  logic [AW-1:0]                 visit_addr,
   input  logic [gbt_pkg::VERTEX_W-1:0]  visit_data,
   input  gbt_pkg::emit_ctl_type         ctl,
   input  logic [CW-1:0]                 count,
   output logic                          busy,
   output logic                          rsp_valid,
   output logic [gbt_pkg::VERTEX_W-1:0]  rsp_vertex,
   output logic                          rsp_last,
   output logic                          rsp_complete,
   output logic                          rsp_edges_dropped
);
   import gbt_pkg::*;

   logic [VERTEX_W-1:0] visit_mem [MAX_VERTICES];
   logic [VERTEX_W-1:0] rd_ff;
   logic [CW-1:0]       k_ff, k_in, total_ff;
   logic                run_ff, pend_ff, last_ff, complete_ff, dropped_ff;
   logic                final_rd;

   assign k_in     = k_ff + CW'(1);
   assign final_rd = (k_in == total_ff);

   always_ff @(posedge clock) begin
      if (visit_we) begin
         visit_mem[visit_addr] <= visit_data;
      end
      rd_ff <= visit_mem[k_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         pend_ff <= 1'b0;
         k_ff    <= '0;
      end else begin
         pend_ff <= run_ff;
         if (ctl.start) begin
            run_ff      <= 1'b1;
            k_ff        <= '0;
            total_ff    <= count;
            complete_ff <= ctl.complete;
            dropped_ff  <= ctl.dropped;
         end else if (run_ff) begin
            k_ff    <= k_in;
            last_ff <= final_rd;
            if (final_rd) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   assign busy              = run_ff | pend_ff;
   assign rsp_valid         = pend_ff;
   assign rsp_vertex        = rd_ff;
   assign rsp_last          = last_ff;
   assign rsp_complete      = complete_ff;
   assign rsp_edges_dropped = dropped_ff;

endmodule

FILE: sim/graph_bfs_dfs_traversal_tb.sv
// Testbench for the graph walker: adjacency-list builds, BFS and DFS walks.
// Keeps its own graph model in a scoreboard class and checks every visited vertex.
// Depends on gbt_pkg and graph_bfs_dfs_traversal.
module graph_bfs_dfs_traversal_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import gbt_pkg::*;

   typedef struct packed {
      logic [5:0] vertex;
      logic       last;
      logic       complete;
      logic       dropped;
   } visit_type;

   class walk_scoreboard;
      int unsigned vcount_reg;
      int unsigned start_reg;
      bit [5:0]    dst_of[256];
      int unsigned next_of[256];
      int unsigned head_of[64];
      int unsigned tail_of[64];
      bit [63:0]   has_list;
      int unsigned n_entries;
      bit          dropped;
      visit_type   pending[$];
      int          errors;

      function new();
         vcount_reg = 64; start_reg = 0; has_list = '0; n_entries = 0;
         dropped = 0; errors = 0;
      endfunction

      function int unsigned vlimit();
         if (vcount_reg == 0) return 1;
         if (vcount_reg > 64) return 64;
         return vcount_reg;
      endfunction

      function void write_reg(logic idx, int unsigned val);
         if (idx == REG_NUM_VERTICES) vcount_reg = val & 127;
         else start_reg = val & 63;
      endfunction

      function void link(int unsigned s, int unsigned d);
         if (n_entries >= 256) begin
            dropped = 1;
            return;
         end
         dst_of[n_entries] = d[5:0];
         next_of[n_entries] = 0;
         if (has_list[s]) next_of[tail_of[s]] = n_entries;
         else begin
            head_of[s] = n_entries;
            has_list[s] = 1;
         end
         tail_of[s] = n_entries;
         n_entries++;
      endfunction

      function void walk(bit deep);
         int unsigned n, cnt, idx, w, v, front, back;
         bit [5:0]    ord[64];
         bit [5:0]    got[$];
         bit [63:0]   seen;
         visit_type   r;
         n = vlimit(); cnt = 0; front = 0; back = 0;
         if (start_reg >= n) return;
         ord[0] = start_reg[5:0]; back = 1; seen = 64'd1 << start_reg;
         while (cnt < n && back > front) begin
            if (deep) begin
               back--;
               v = ord[back];
            end else begin
               v = ord[front];
               front++;
            end
            got = {got, v[5:0]};
            cnt++;
            if (has_list[v]) begin
               idx = head_of[v];
               for (int s = 0; s < 256; s++) begin
                  w = dst_of[idx];
                  if (w < n && !seen[w] && back < 64) begin
                     seen[w] = 1;
                     ord[back] = w[5:0];
                     back++;
                  end
                  if (idx == tail_of[v]) break;
                  idx = next_of[idx];
               end
            end
         end
         foreach (got[k]) begin
            r.vertex = got[k];
            r.last = (k + 1 == cnt);
            r.complete = (cnt == n);
            r.dropped = dropped;
            pending = {pending, r};
         end
      endfunction

      function void note_item(logic [1:0] cmd, int unsigned s, int unsigned d, bit bw);
         int unsigned n;
         n = vlimit();
         case (cmd)
            CMD_ADD_EDGE: begin
               if (s >= n || d >= n) dropped = 1;
               else begin
                  link(s, d);
                  if (bw) link(d, s);
               end
            end
            CMD_BFS: walk(0);
            CMD_DFS: walk(1);
            default: ;
         endcase
      endfunction

      function void check(visit_type got);
         visit_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result exp none act %p", $time, got);
            errors++;
            return;
         end
         want = pending[0];
         pending.delete(0);
         if (got.vertex !== want.vertex) begin
            $display("%0t: vertex exp %0d act %0d", $time, want.vertex, got.vertex);
            errors++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last exp %0d act %0d", $time, want.last, got.last);
            errors++;
         end
         if (got.complete !== want.complete) begin
            $display("%0t: complete exp %0d act %0d", $time, want.complete, got.complete);
            errors++;
         end
         if (got.dropped !== want.dropped) begin
            $display("%0t: edges_dropped exp %0d act %0d", $time, want.dropped, got.dropped);
            errors++;
         end
      endfunction
   endclass

   logic       clock, reset, start, busy;
   logic [1:0] req_command;
   logic [5:0] req_from_vertex, req_to_vertex;
   logic       req_both_ways;
   logic       rsp_valid, rsp_last, rsp_complete, rsp_edges_dropped;
   logic [5:0] rsp_vertex;
   logic       csr_write, csr_index;
   logic [6:0] csr_data;

   graph_bfs_dfs_traversal dut (.*);

   walk_scoreboard sb = new();
   int unsigned    idle_pct;
   longint         cycles;

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check({rsp_vertex, rsp_last, rsp_complete, rsp_edges_dropped});
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // start drops low after each accepted item, before the next one is sent
   task automatic send(logic [1:0] cmd, int unsigned s, int unsigned d, bit bw);
      while ($urandom_range(99) < idle_pct) @(posedge clock);
      start <= 1;
      req_command <= cmd;
      req_from_vertex <= s[5:0];
      req_to_vertex <= d[5:0];
      req_both_ways <= bw;
      do @(posedge clock); while (busy);
      sb.note_item(cmd, s, d, bw);
      start <= 0;
      @(posedge clock);
   endtask

   // registers change only when the walker is quiet
   task automatic drain();
      while (sb.pending.size() != 0 || busy) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_reg(logic idx, int unsigned val);
      drain();
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val[6:0];
      @(posedge clock);
      sb.write_reg(idx, val);
      csr_write <= 0;
   endtask

   task automatic random_phase(int items, int unsigned nv);
      int unsigned r;
      set_reg(REG_NUM_VERTICES, nv);
      set_reg(REG_START_VERTEX, $urandom_range(nv > 64 ? 63 : (nv == 0 ? 0 : nv - 1)));
      for (int i = 0; i < items; i++) begin
         r = $urandom_range(99);
         if (r < 70)
            send(CMD_ADD_EDGE,
                 r < 65 ? $urandom_range(nv - 1) : $urandom_range(63),
                 r < 65 ? $urandom_range(nv - 1) : $urandom_range(63),
                 1'($urandom_range(1)));
         else if (r < 83) send(CMD_BFS, 0, 0, 1'b0);
         else if (r < 96) send(CMD_DFS, 0, 0, 1'b0);
         else send(CMD_NOP, $urandom_range(63), $urandom_range(63), 1'($urandom_range(1)));
      end
   endtask

   initial begin
      cycles = 0;
      reset <= 1; start <= 0; req_command <= CMD_NOP;
      req_from_vertex <= 0; req_to_vertex <= 0; req_both_ways <= 0;
      csr_write <= 0; csr_index <= REG_NUM_VERTICES; csr_data <= 0;
      idle_pct = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty walks, extremes, self loop, out-of-range endpoints
      send(CMD_BFS, 0, 0, 0);
      send(CMD_ADD_EDGE, 0, 63, 1);
      send(CMD_ADD_EDGE, 63, 63, 1);
      send(CMD_ADD_EDGE, 0, 1, 0);
      send(CMD_ADD_EDGE, 1, 2, 1);
      send(CMD_ADD_EDGE, 2, 0, 0);
      send(CMD_BFS, 0, 0, 0);
      send(CMD_DFS, 0, 0, 0);
      send(CMD_NOP, 63, 63, 1);
      set_reg(REG_NUM_VERTICES, 3);
      send(CMD_ADD_EDGE, 5, 1, 0);
      send(CMD_BFS, 0, 0, 0);
      set_reg(REG_START_VERTEX, 63);
      send(CMD_DFS, 0, 0, 0);
      set_reg(REG_NUM_VERTICES, 0);
      set_reg(REG_START_VERTEX, 0);
      send(CMD_BFS, 0, 0, 0);
      set_reg(REG_NUM_VERTICES, 127);
      send(CMD_DFS, 0, 0, 0);
      set_reg(REG_NUM_VERTICES, 1);
      send(CMD_ADD_EDGE, 0, 0, 1);
      send(CMD_DFS, 0, 0, 0);

      idle_pct = 30;
      random_phase(60, 64);
      random_phase(60, 8);
      drain();
      idle_pct = 71;
      random_phase(60, 64);
      random_phase(40, 2);
      idle_pct = 0;
      random_phase(80, 16);
      random_phase(60, 64);

      drain();
      repeat (100) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/gbt_pkg.sv
hw/rtl/gbt_emit.sv
hw/rtl/graph_bfs_dfs_traversal.sv
sim/graph_bfs_dfs_traversal_tb.sv
